[rtl/core/assert_macros.svh]
// Assertion macros for the timer RTL.
// No dependencies; included by plct_eval, the module that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check prop at every rising clock edge, outside of reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that cond never holds at a rising clock edge, outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLKD(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[rtl/core/plct_pkg.sv]
// Types and constants of the scan timer.
// No dependencies; used by plct_in_stage, plct_eval and the top level.
package plct_pkg;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMER_MODE     = 1'd0,
    CFG_DEFAULT_PRESET = 1'd1
  } plct_cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_ON_DELAY  = 3'd1,
    MODE_OFF_DELAY = 3'd2,
    MODE_PULSE     = 3'd3
  } plct_mode_e;

  localparam logic [2:0] TimerModeReset = MODE_ON_DELAY;

  typedef struct packed {
    logic [31:0] now_time;
    logic        enable;
    logic        reset_req;
    logic        preset_valid;
    logic [31:0] preset_value;
  } plct_in_t;

  typedef struct packed {
    logic        q_out;
    logic [31:0] elapsed;
  } plct_out_t;

  typedef struct packed {
    logic        valid;
    plct_in_t    item;
  } plct_stage_t;

  typedef struct packed {
    logic [2:0]  timer_mode;
    logic [31:0] default_preset;
  } plct_cfg_t;

endpackage

[rtl/core/plct_stream_if.sv]
// Valid/ready channel carrying one payload item per transfer.
// Payload type comes from plct_pkg through the type parameter.
interface plct_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/plct_in_stage.sv]
// Input register of the scan timer: holds one scan item until evaluated.
// Depends on plct_pkg and plct_stream_if.
module plct_in_stage import plct_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  plct_stream_if.sink  in_ch,
  input  logic         advance_i,
  output plct_stage_t  stage_o
);

  logic     valid_q;
  plct_in_t item_q;

  // Take a new scan when empty or when the held one moves on this cycle.
  assign in_ch.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      item_q <= in_ch.payload;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

[rtl/core/plct_eval.sv]
// Timer state and per-scan update for the on-delay, off-delay and pulse modes.
// Depends on plct_pkg and assert_macros.svh.
`include "assert_macros.svh"
module plct_eval import plct_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  plct_in_t  item_i,
  input  plct_cfg_t cfg_i,
  output plct_out_t result_o
);

  localparam int unsigned DiffW = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;

  logic [31:0] start_q, start_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic        out_q, out_d;
  logic        last_en_q, last_en_d;
  logic        running_q, running_d;

  logic [31:0]      preset;
  logic [DiffW-1:0] diff;
  logic [31:0]      since_start;
  logic             arm;
  logic             active;
  logic [31:0]      period_time;

  assign preset      = item_i.preset_valid ? item_i.preset_value : cfg_i.default_preset;
  assign diff        = item_i.now_time[DiffW-1:0] - start_q[DiffW-1:0];
  assign since_start = 32'(diff);

  always_comb begin
    start_d     = start_q;
    elapsed_d   = elapsed_q;
    out_d       = out_q;
    running_d   = running_q;
    last_en_d   = last_en_q;
    arm         = 1'b0;
    active      = 1'b0;
    period_time = since_start;
    if (advance_i) begin
      last_en_d = item_i.enable;
      if (item_i.reset_req) begin
        elapsed_d = '0;
        out_d     = (cfg_i.timer_mode == MODE_OFF_DELAY);
        running_d = 1'b0;
        start_d   = '0;
      end else begin
        case (cfg_i.timer_mode)
          MODE_ON_DELAY: begin
            if (item_i.enable) begin
              if (!running_q) begin
                start_d   = item_i.now_time;
                running_d = 1'b1;
                out_d     = 1'b0;
              end else if (since_start >= preset) begin
                out_d     = 1'b1;
                elapsed_d = preset;
              end else begin
                elapsed_d = since_start;
              end
            end else begin
              elapsed_d = '0;
              out_d     = 1'b0;
              running_d = 1'b0;
            end
          end
          MODE_OFF_DELAY: begin
            if (item_i.enable) begin
              arm    = !running_q && !last_en_q;
              active = running_q || arm;
              if (!active) begin
                out_d     = 1'b0;
                elapsed_d = '0;
              end
            end else begin
              elapsed_d = '0;
              out_d     = 1'b1;
              running_d = 1'b0;
            end
          end
          MODE_PULSE: begin
            arm    = item_i.enable && !last_en_q && !running_q;
            active = running_q || arm;
          end
          default: begin
            // Hold the timer state for the modes that are not implemented.
          end
        endcase
        // Shared period logic; a fresh start measures zero time.
        if (arm) begin
          start_d     = item_i.now_time;
          period_time = '0;
        end
        if (active) begin
          if (period_time >= preset) begin
            out_d     = 1'b0;
            running_d = 1'b0;
            elapsed_d = preset;
          end else begin
            out_d     = 1'b1;
            running_d = 1'b1;
            elapsed_d = period_time;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= '0;
      elapsed_q <= '0;
      out_q     <= 1'b0;
      last_en_q <= 1'b0;
      running_q <= 1'b0;
    end else begin
      start_q   <= start_d;
      elapsed_q <= elapsed_d;
      out_q     <= out_d;
      last_en_q <= last_en_d;
      running_q <= running_d;
    end
  end

  assign result_o.q_out   = out_d;
  assign result_o.elapsed = elapsed_d;

  `ASSERT_CLKD(a_reset_clears, clk_i, rst_ni, advance_i && item_i.reset_req |=> elapsed_q == 32'd0 && !running_q && start_q == 32'd0, "reset request left timer state set")
  `ASSERT_CLKD(a_edge_memory, clk_i, rst_ni, advance_i |=> last_en_q == $past(item_i.enable), "last enable does not follow the scan")
  `ASSERT_CLKD(a_idle_mode_holds, clk_i, rst_ni, advance_i && !item_i.reset_req && cfg_i.timer_mode != MODE_ON_DELAY && cfg_i.timer_mode != MODE_OFF_DELAY && cfg_i.timer_mode != MODE_PULSE |=> $stable(start_q) && $stable(elapsed_q) && $stable(running_q) && $stable(out_q), "unimplemented mode changed timer state")
  `ASSERT_NEVER(a_hold_without_scan, clk_i, rst_ni, !advance_i && (start_d != start_q || elapsed_d != elapsed_q || running_d != running_q), "timer state moved without a scan")

endmodule

[rtl/core/plc_timer_ton_tof_tp.sv]
// Top level of the PLC scan timer with on-delay, off-delay and pulse modes.
// Depends on plct_pkg, plct_stream_if, plct_in_stage and plct_eval.
//
// One scan item in, one result out (Q and elapsed time ET in ms). A scan is
// held in an input register, evaluated combinationally against the timer
// state (one subtract of up to 32 bits, one compare and the mode selection)
// and the updated Q and ET land in the output register in the same cycle the
// state registers update. A result passes the input register and then the
// output register before it transfers; a new scan is taken every cycle as
// long as the result side keeps taking transfers. While a finished result
// waits, the input register takes one more scan and then holds ready low
// until the result transfers. Elapsed time is the difference of now_time
// and the start stamp modulo 2^TIME_WIDTH, kept to 32 bits and clamped to
// the preset.
// Configuration (mode, default preset) is written through cfg_we_i/cfg_idx_i/
// cfg_data_i while no scan is in flight; mode values other than 1, 2 and 3
// freeze the timer, while a reset request still clears it.
module plc_timer_ton_tof_tp import plct_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  plct_stream_if.sink         in_ch,
  plct_stream_if.source       out_ch
);

  plct_cfg_t   cfg_q;
  plct_stage_t stage;
  plct_out_t   result;
  plct_out_t   out_data_q;
  logic        out_valid_q;
  logic        advance;

  // Configuration registers; only two indexes exist, both are decoded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timer_mode     <= TimerModeReset;
      cfg_q.default_preset <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIMER_MODE:     cfg_q.timer_mode     <= cfg_data_i[2:0];
        CFG_DEFAULT_PRESET: cfg_q.default_preset <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Advance the held scan when the output register is empty or drains now.
  assign advance = stage.valid && (!out_valid_q || out_ch.ready);

  plct_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .advance_i (advance),
    .stage_o   (stage)
  );

  plct_eval #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (stage.item),
    .cfg_i     (cfg_q),
    .result_o  (result)
  );

  // Output register: load on advance, drop valid once the transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.payload = out_data_q;

endmodule
